// File: src/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, constants and the arctangent table for the coil combiner.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int PHASE_FRAC_DEF = 13;

    // CORDIC: iterations, angle fraction bits, constants in Q20 radians
    localparam int ITERS       = 20;
    localparam int ANG_FRAC    = 20;
    localparam int PI_Q20      = 3294199;
    localparam int HALF_PI_Q20 = 1647099;
    localparam int GAIN_Q20    = 636751;

    localparam int SAMP_W  = 16;
    localparam int POWER_W = 37;
    localparam int WSUM_W  = 52;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;

    // vectoring datapath in the front
    localparam int VX_W = 34;
    localparam int VZ_W = 25;

    // back end: quotient bits, square root steps, rotation datapath
    localparam int DIV_QW   = 22;
    localparam int SQ_IN_W  = 54;
    localparam int SQ_ITERS = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_ITERS + 2;
    localparam int MQ_W     = SQ_ITERS + 1;
    localparam int CX_W     = 38;

    localparam int Q_DEPTH = 2;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SCALE  = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    typedef struct packed {
        logic [POWER_W-1:0]       power;
        logic signed [WSUM_W-1:0] wsum;
    } t_pix;

    typedef struct packed {
        logic                    mode;
        logic signed [CFG_W-1:0] scale;
        logic signed [CFG_W-1:0] offset;
    } t_cfg;

    function automatic logic [19:0] atan_q20(input logic [4:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/mri_coil_combine.sv
// ----------------------------------------------------------------------------
// mri_coil_combine
// Root-sum-of-squares / power-weighted phase coil combiner.
// ----------------------------------------------------------------------------
// A pixel arrives as a run of complex coil samples, the final one marked by
// i_last_coil; one result per pixel. The front finishes each sample before
// taking the next: a 20-step vectoring CORDIC for the sample phase, one
// multiply and one accumulate. Finished pixel sums pass through a two-entry
// queue to the back, which in mode 0 runs a 22-step divide, a 27-step square
// root, a 20-step rotation CORDIC and scaling, and in mode 1 only the square
// root, overlapped with the front's work on the next pixel. Configuration
// writes are always accepted; the mode is sampled when the back takes a
// pixel from the queue, scale and offset when the result is scaled.
// ----------------------------------------------------------------------------
module mri_coil_combine import mcc_pkg::*; #(
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [SAMP_W-1:0] i_coil_re,
    input  logic signed [SAMP_W-1:0] i_coil_im,
    input  logic                     i_last_coil,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_out_re,
    output logic signed [OUT_W-1:0]  o_out_im,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cfg r_cfg;
    logic q_full, q_empty, push, pop;
    t_pix push_pix, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= 1'b0;
            r_cfg.scale  <= CFG_W'(256);
            r_cfg.offset <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                CFG_SCALE:  r_cfg.scale  <= i_cfg_data;
                CFG_OFFSET: r_cfg.offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcc_front #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_coil_re   (i_coil_re),
        .i_coil_im   (i_coil_im),
        .i_last_coil (i_last_coil),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_pix       (push_pix)
    );

    mcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (push_pix),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    mcc_back #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out_re (o_out_re),
        .o_out_im (o_out_im)
    );

endmodule

// File: src/mcc_front.sv
// ----------------------------------------------------------------------------
// mcc_front
// Takes coil samples, finds power and phase (vectoring CORDIC), accumulates
// the pixel sums and pushes finished pixels into the queue.
// ----------------------------------------------------------------------------
module mcc_front import mcc_pkg::*; #(
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [SAMP_W-1:0] i_coil_re,
    input  logic signed [SAMP_W-1:0] i_coil_im,
    input  logic                     i_last_coil,
    input  logic                     i_q_full,
    output logic                     o_push,
    output t_pix                     o_pix
);

    localparam int SH  = ANG_FRAC - PHASE_FRAC_BITS;
    localparam int PHW = PHASE_FRAC_BITS + 4;
    localparam int WPW = PHW + 33;
    localparam logic signed [VZ_W-1:0] ZRND = VZ_W'(2 ** (SH - 1));

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ITER = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_ACC  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic signed [VX_W-1:0]   r_x, r_y;
    logic signed [VZ_W-1:0]   r_z;
    logic [4:0]               r_it;
    logic [31:0]              r_p;
    logic                     r_last, r_zero;
    logic signed [WPW-1:0]    r_wp;
    logic [POWER_W-1:0]       r_psum;
    logic signed [WSUM_W-1:0] r_wsum;

    logic signed [VX_W-1:0]   a_x, a_y, sx, sy;
    logic signed [31:0]       sq_re, sq_im;
    logic signed [VZ_W-1:0]   tz, atan_v;
    logic signed [PHW-1:0]    ph;
    logic [POWER_W:0]         ps;
    logic [POWER_W-1:0]       ps_sat;
    logic signed [WSUM_W:0]   ws;
    logic signed [WSUM_W-1:0] ws_sat;

    assign o_ready = (r_state == F_IDLE);
    assign a_x     = {{(VX_W-30){i_coil_re[15]}}, i_coil_re, 14'b0};
    assign a_y     = {{(VX_W-30){i_coil_im[15]}}, i_coil_im, 14'b0};
    assign sq_re   = i_coil_re * i_coil_re;
    assign sq_im   = i_coil_im * i_coil_im;
    assign sx      = r_x >>> r_it;
    assign sy      = r_y >>> r_it;
    assign atan_v  = VZ_W'(atan_q20(r_it));
    assign tz      = r_z + ZRND;
    assign ph      = r_zero ? '0 : PHW'(tz >>> SH);

    // saturating accumulation
    assign ps     = {1'b0, r_psum} + (POWER_W+1)'(r_p);
    assign ps_sat = ps[POWER_W] ? '1 : ps[POWER_W-1:0];
    assign ws     = (WSUM_W+1)'(r_wsum) + (WSUM_W+1)'(r_wp);
    always_comb begin
        if (ws[WSUM_W] != ws[WSUM_W-1]) begin
            ws_sat = ws[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
        end else begin
            ws_sat = ws[WSUM_W-1:0];
        end
    end

    assign o_push      = (r_state == F_ACC) && r_last && !i_q_full;
    assign o_pix.power = ps_sat;
    assign o_pix.wsum  = ws_sat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_ITER;
            F_ITER: if (r_it == 5'(ITERS - 1)) n_state = F_MUL;
            F_MUL:  n_state = F_ACC;
            F_ACC:  if (!r_last || !i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_psum  <= '0;
            r_wsum  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_p    <= 32'(sq_re) + 32'(sq_im);
                        r_zero <= (i_coil_re == '0) && (i_coil_im == '0);
                        r_last <= i_last_coil;
                        r_it   <= '0;
                        // left half plane: rotate by pi first
                        if (i_coil_re[15]) begin
                            r_x <= -a_x;
                            r_y <= -a_y;
                            r_z <= i_coil_im[15] ? -VZ_W'(PI_Q20) : VZ_W'(PI_Q20);
                        end else begin
                            r_x <= a_x;
                            r_y <= a_y;
                            r_z <= '0;
                        end
                    end
                end
                F_ITER: begin
                    r_it <= r_it + 5'd1;
                    if (r_y > 0) begin
                        r_x <= r_x + sy;
                        r_y <= r_y - sx;
                        r_z <= r_z + atan_v;
                    end else begin
                        r_x <= r_x - sy;
                        r_y <= r_y + sx;
                        r_z <= r_z - atan_v;
                    end
                end
                F_MUL: begin
                    r_wp <= $signed({1'b0, r_p}) * ph;
                end
                F_ACC: begin
                    if (!r_last) begin
                        r_psum <= ps_sat;
                        r_wsum <= ws_sat;
                    end else if (!i_q_full) begin
                        r_psum <= '0;
                        r_wsum <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: src/mcc_queue.sv
// ----------------------------------------------------------------------------
// mcc_queue
// Small FIFO of finished pixel sums between front and back.
// ----------------------------------------------------------------------------
module mcc_queue import mcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pix,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_pix o_head
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_pix          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

// File: src/mcc_back.sv
// ----------------------------------------------------------------------------
// mcc_back
// Per pixel: mean phase divide, square root, gain, rotation CORDIC, scale,
// offset, saturation (mode 1: root, saturation); held in the output register.
// ----------------------------------------------------------------------------
module mcc_back import mcc_pkg::*; #(
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_pix                    i_head,
    output logic                    o_pop,
    input  t_cfg                    i_cfg,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_out_re,
    output logic signed [OUT_W-1:0] o_out_im
);

    localparam int SH  = ANG_FRAC - PHASE_FRAC_BITS;
    localparam int ZRW = DIV_QW + SH + 2;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_DIV  = 4'd1;
    localparam logic [3:0] B_SQRT = 4'd2;
    localparam logic [3:0] B_RND  = 4'd3;
    localparam logic [3:0] B_GAIN = 4'd4;
    localparam logic [3:0] B_PRE  = 4'd5;
    localparam logic [3:0] B_ROT  = 4'd6;
    localparam logic [3:0] B_MX   = 4'd7;
    localparam logic [3:0] B_MY   = 4'd8;
    localparam logic [3:0] B_FIN  = 4'd9;
    localparam logic [3:0] B_DONE = 4'd10;

    logic [3:0]               r_state;
    logic [4:0]               r_cnt;
    logic [POWER_W-1:0]       r_pw;
    logic                     r_neg, r_mode;
    logic [POWER_W-1:0]       r_rem;
    logic [DIV_QW-1:0]        r_num, r_q;
    logic [SQ_IN_W-1:0]       r_sqv;
    logic [SQ_REM_W-1:0]      r_srem;
    logic [SQ_ITERS-1:0]      r_root;
    logic [MQ_W-1:0]          r_mq;
    logic [MQ_W+19:0]         r_prod;
    logic signed [CX_W-1:0]   r_cx, r_cy;
    logic signed [ZRW-1:0]    r_cz;
    logic signed [CX_W+15:0]  r_mprod;
    logic signed [OUT_W-1:0]  r_res_re, r_res_im;
    logic                     r_ovalid;
    logic signed [OUT_W-1:0]  r_ore, r_oim;

    logic [WSUM_W-1:0]        a_abs;
    logic [WSUM_W:0]          n_div;
    logic [POWER_W:0]         d_rem2;
    logic                     d_ge;
    logic [SQ_REM_W+1:0]      s_rem2, s_trial;
    logic                     s_ge;
    logic [MQ_W+19:0]         g_rnd;
    logic signed [DIV_QW:0]   ph;
    logic signed [ZRW-1:0]    z0;
    logic signed [CX_W-1:0]   x0, sx, sy;
    logic signed [ZRW-1:0]    atan_v;
    logic signed [CFG_W-1:0]  scl;
    logic                     out_free;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [31:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 32'(OUT_MAX)) begin
            r = OUT_W'(OUT_MAX);
        end else if (v < 32'(OUT_MIN)) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    // round the Q24 product to an integer, add offset, saturate
    function automatic logic signed [OUT_W-1:0] finish(input logic signed [CX_W+15:0] m,
                                                       input logic signed [CFG_W-1:0] off);
        logic signed [CX_W+16:0] t;
        logic signed [31:0]      u;
        t = (CX_W+17)'(m) + (CX_W+17)'(2 ** 23);
        u = 32'(t >>> 24) + 32'(off);
        return sat_out(u);
    endfunction

    assign a_abs   = i_head.wsum[WSUM_W-1] ? WSUM_W'(-i_head.wsum) : WSUM_W'(i_head.wsum);
    assign n_div   = {1'b0, a_abs} + (WSUM_W+1)'(i_head.power >> 1);
    assign d_rem2  = {r_rem, r_num[DIV_QW-1]};
    assign d_ge    = d_rem2 >= {1'b0, r_pw};
    assign s_rem2  = {r_srem, r_sqv[SQ_IN_W-1 -: 2]};
    assign s_trial = {2'b0, r_root, 2'b01};
    assign s_ge    = s_rem2 >= s_trial;
    assign g_rnd   = r_prod + (MQ_W+20)'(2048);
    assign x0      = CX_W'(g_rnd >> 12);
    assign ph      = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign z0      = ZRW'(ph) <<< SH;
    assign sx      = r_cx >>> r_cnt;
    assign sy      = r_cy >>> r_cnt;
    assign atan_v  = ZRW'(atan_q20(r_cnt));
    assign scl     = (i_cfg.scale == '0) ? CFG_W'(256) : i_cfg.scale;
    assign out_free = !r_ovalid || i_ready;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_valid  = r_ovalid;
    assign o_out_re = r_ore;
    assign o_out_im = r_oim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // B_DONE sets valid itself when the register frees up
            if (r_ovalid && i_ready && (r_state != B_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_pw   <= i_head.power;
                        r_neg  <= i_head.wsum[WSUM_W-1];
                        r_mode <= i_cfg.mode;
                        r_rem  <= POWER_W'(n_div[WSUM_W:DIV_QW]);
                        r_num  <= n_div[DIV_QW-1:0];
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_srem <= '0;
                        r_root <= '0;
                        r_sqv  <= i_cfg.mode ? SQ_IN_W'(i_head.power)
                                             : SQ_IN_W'({i_head.power, 16'b0});
                        // zero power: phase stays 0, no divide
                        if (i_cfg.mode || (i_head.power == '0)) begin
                            r_state <= B_SQRT;
                        end else begin
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    r_rem <= d_ge ? POWER_W'(d_rem2 - {1'b0, r_pw}) : d_rem2[POWER_W-1:0];
                    r_num <= r_num << 1;
                    r_q   <= {r_q[DIV_QW-2:0], d_ge};
                    if (r_cnt == 5'(DIV_QW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                B_SQRT: begin
                    r_srem <= s_ge ? SQ_REM_W'(s_rem2 - s_trial) : SQ_REM_W'(s_rem2);
                    r_root <= {r_root[SQ_ITERS-2:0], s_ge};
                    r_sqv  <= r_sqv << 2;
                    if (r_cnt == 5'(SQ_ITERS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_RND;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                B_RND: begin
                    r_mq    <= MQ_W'(r_root) + MQ_W'(r_srem > SQ_REM_W'(r_root));
                    r_state <= B_GAIN;
                end
                B_GAIN: begin
                    if (r_mode) begin
                        r_res_re <= sat_out(32'(r_mq));
                        r_res_im <= '0;
                        r_state  <= B_DONE;
                    end else begin
                        r_prod  <= r_mq * 20'(GAIN_Q20);
                        r_state <= B_PRE;
                    end
                end
                B_PRE: begin
                    r_cy  <= '0;
                    r_cnt <= '0;
                    if (z0 > ZRW'(HALF_PI_Q20)) begin
                        r_cx <= -x0;
                        r_cz <= z0 - ZRW'(PI_Q20);
                    end else if (z0 < -ZRW'(HALF_PI_Q20)) begin
                        r_cx <= -x0;
                        r_cz <= z0 + ZRW'(PI_Q20);
                    end else begin
                        r_cx <= x0;
                        r_cz <= z0;
                    end
                    r_state <= B_ROT;
                end
                B_ROT: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - sy;
                        r_cy <= r_cy + sx;
                        r_cz <= r_cz - atan_v;
                    end else begin
                        r_cx <= r_cx + sy;
                        r_cy <= r_cy - sx;
                        r_cz <= r_cz + atan_v;
                    end
                    if (r_cnt == 5'(ITERS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_MX;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                B_MX: begin
                    r_mprod <= r_cx * scl;
                    r_state <= B_MY;
                end
                B_MY: begin
                    r_res_re <= finish(r_mprod, i_cfg.offset);
                    r_mprod  <= r_cy * scl;
                    r_state  <= B_FIN;
                end
                B_FIN: begin
                    r_res_im <= finish(r_mprod, i_cfg.offset);
                    r_state  <= B_DONE;
                end
                B_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ore    <= r_res_re;
                        r_oim    <= r_res_im;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// File: src/mcc_checker.sv
// ----------------------------------------------------------------------------
// mcc_checker
// Port-level checks for the coil combiner, bound to the top level.
// ----------------------------------------------------------------------------
module mcc_checker import mcc_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic signed [SAMP_W-1:0] i_coil_re,
    input logic signed [SAMP_W-1:0] i_coil_im,
    input logic                     i_last_coil,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [OUT_W-1:0]  o_out_re,
    input logic signed [OUT_W-1:0]  o_out_im,
    input logic                     i_cfg_valid,
    input logic                     o_cfg_ready,
    input logic [1:0]               i_cfg_index,
    input logic [CFG_W-1:0]         i_cfg_data
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_re) && $stable(o_out_im))
        else $error("output changed while stalled");

    // no result can be pending straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // the front stays busy with an item after taking it, not taking the next at once
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("front took items too fast");

    // the configuration port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind mri_coil_combine mcc_checker u_mcc_checker (.*);
